### sv/aes128_pkg.sv
// Shared types, constants and round functions for the AES-128 encryption pipeline.
package aes128_pkg;

	localparam int ROUNDS = 10;

	// Configuration register indexes.
	localparam logic REG_KEY_HIGH = 1'b0;
	localparam logic REG_KEY_LOW  = 1'b1;

	// Round constants for the key schedule, first round at index 0.
	localparam logic [7:0] RCON [ROUNDS] = '{
		8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1B, 8'h36
	};

	// Forward substitution box.
	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
		8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
		8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
		8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
		8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
		8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
		8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
		8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
		8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
		8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
		8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
		8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
		8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
		8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
		8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
		8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
	};

	// Data and round key that travel together down the pipeline.
	typedef struct packed {
		logic [127:0] state;
		logic [127:0] rkey;
	} aes128_stage_t;

	// Multiply by x in GF(2^8).
	function automatic logic [7:0] xtime(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1B : 8'h00);
	endfunction

	// Apply the S-box to all sixteen bytes.
	function automatic logic [127:0] sub_bytes(input logic [127:0] s);
		logic [127:0] r;
		r = '0;
		for (int k = 0; k < 16; k++) begin
			r[127 - 8 * k -: 8] = SBOX[s[127 - 8 * k -: 8]];
		end
		return r;
	endfunction

	// Rotate row r left by r positions; byte k sits at row k mod 4, column k div 4.
	function automatic logic [127:0] shift_rows(input logic [127:0] s);
		logic [127:0] r;
		r = '0;
		for (int row = 0; row < 4; row++) begin
			for (int col = 0; col < 4; col++) begin
				r[127 - 8 * (row + 4 * col) -: 8] =
					s[127 - 8 * (row + 4 * ((col + row) & 3)) -: 8];
			end
		end
		return r;
	endfunction

	// MixColumns on one column, first byte most significant.
	function automatic logic [31:0] mix_col(input logic [31:0] c);
		logic [7:0] a0, a1, a2, a3, t;
		a0 = c[31:24];
		a1 = c[23:16];
		a2 = c[15:8];
		a3 = c[7:0];
		t  = a0 ^ a1 ^ a2 ^ a3;
		return {a0 ^ t ^ xtime(a0 ^ a1), a1 ^ t ^ xtime(a1 ^ a2),
			a2 ^ t ^ xtime(a2 ^ a3), a3 ^ t ^ xtime(a3 ^ a0)};
	endfunction

	// MixColumns over the four columns.
	function automatic logic [127:0] mix_columns(input logic [127:0] s);
		logic [127:0] r;
		r = '0;
		for (int col = 0; col < 4; col++) begin
			r[127 - 32 * col -: 32] = mix_col(s[127 - 32 * col -: 32]);
		end
		return r;
	endfunction

	// One step of the key expansion.
	function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
		logic [31:0] t;
		logic [31:0] w [4];
		t = {SBOX[k[23:16]] ^ rc, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
		w[0] = k[127:96] ^ t;
		w[1] = k[95:64] ^ w[0];
		w[2] = k[63:32] ^ w[1];
		w[3] = k[31:0] ^ w[2];
		return {w[0], w[1], w[2], w[3]};
	endfunction

endpackage

### sv/aes128_round.sv
// One registered AES round together with the matching key schedule step.
module aes128_round (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_vld,
	output logic                   in_rdy,
	input  aes128_pkg::aes128_stage_t in_stg,
	input  logic [7:0]             rcon,
	input  logic                   last_rnd,
	output logic                   out_vld,
	input  logic                   out_rdy,
	output aes128_pkg::aes128_stage_t out_stg
);
	import aes128_pkg::*;

	logic          vld_s1;
	aes128_stage_t stg_s1;
	logic [127:0]  shifted;
	logic [127:0]  mixed;
	logic [127:0]  key_nxt;

	// The stage takes a new transaction when empty or when its content moves on.
	assign in_rdy = !vld_s1 || out_rdy;

	// Round datapath: SubBytes, ShiftRows, MixColumns except in the final round.
	always_comb begin
		shifted = shift_rows(sub_bytes(in_stg.state));
		mixed   = last_rnd ? shifted : mix_columns(shifted);
		key_nxt = next_key(in_stg.rkey, rcon);
	end

	// Valid bit of this stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_rdy) begin
			vld_s1 <= in_vld;
		end
	end

	// Payload register: state after AddRoundKey and the round key used.
	always_ff @(posedge clk) begin
		if (in_rdy && in_vld) begin
			stg_s1.state <= mixed ^ key_nxt;
			stg_s1.rkey  <= key_nxt;
		end
	end

	assign out_vld = vld_s1;
	assign out_stg = stg_s1;

endmodule

### sv/aes128_block_encrypt.sv
// Top level of the pipelined AES-128 encryption engine.
// Pipeline: one key-add stage plus ten round stages, each registered, between an accepted block and its ciphertext.
// Throughput: one block per cycle while the output is not stalled; each round has its own stage with its own key step.
// A stalled output holds its stage; upstream stages keep filling any empty slots.
// Reset clears all stage valid bits and both key registers to zero.
module aes128_block_encrypt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] block_high,
	input  logic [63:0] block_low,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] cipher_high,
	output logic [63:0] cipher_low
);
	import aes128_pkg::*;

	logic [63:0]   key_high_q;
	logic [63:0]   key_low_q;
	logic          vld_s0;
	aes128_stage_t stg_s0;
	logic          vld [ROUNDS + 1];
	logic          rdy [ROUNDS + 2];
	aes128_stage_t stg [ROUNDS + 1];

	// Key register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KEY_HIGH: key_high_q <= cfg_data;
				REG_KEY_LOW:  key_low_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input stage: initial AddRoundKey, carrying the cipher key along.
	assign rdy[0] = !vld_s0 || rdy[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else if (rdy[0]) begin
			vld_s0 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0] && in_valid) begin
			stg_s0.state <= {block_high ^ key_high_q, block_low ^ key_low_q};
			stg_s0.rkey  <= {key_high_q, key_low_q};
		end
	end

	assign vld[0] = vld_s0;
	assign stg[0] = stg_s0;

	// Ten round stages.
	for (genvar i = 1; i <= ROUNDS; i++) begin : g_round
		aes128_round u_round (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_vld   (vld[i - 1]),
			.in_rdy   (rdy[i]),
			.in_stg   (stg[i - 1]),
			.rcon     (RCON[i - 1]),
			.last_rnd (i == ROUNDS),
			.out_vld  (vld[i]),
			.out_rdy  (rdy[i + 1]),
			.out_stg  (stg[i])
		);
	end

	// Output side: the last stage doubles as the output register.
	assign rdy[ROUNDS + 1] = !vld[ROUNDS] || !out_stall;
	assign out_valid       = vld[ROUNDS];
	assign cipher_high     = stg[ROUNDS].state[127:64];
	assign cipher_low      = stg[ROUNDS].state[63:0];
	assign in_stall        = !rdy[0];

`ifndef SYNTHESIS
	// An accepted transaction occupies the input stage on the next cycle.
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> vld_s0)
		else $error("accepted block did not reach the input stage");

	// Backpressure reaches the input only when the output is held.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled while the output is not held");

	// An empty input stage always takes a new transaction.
	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s0 |-> !in_stall)
		else $error("input stalled with an empty input stage");
`endif

endmodule
